// ===== hw/rtl/qmsd_pkg.sv =====
// Shared types and constants for the quantized mesh stream decoder.
`timescale 1ns / 1ps

package qmsd_pkg;

    localparam int unsigned HEADER_BYTES_DEFAULT = 88;
    localparam int unsigned HDR_CNT_W            = 7;
    localparam int unsigned WORD_W               = 32;
    localparam int unsigned COORD_W              = 16;
    localparam int unsigned QUEUE_DEPTH          = 2;
    localparam logic [WORD_W-1:0] WIDE_LIMIT     = 32'd65536;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_VCOUNT = 3'd1,
        PH_U      = 3'd2,
        PH_V      = 3'd3,
        PH_HEIGHT = 3'd4,
        PH_TCOUNT = 3'd5,
        PH_INDEX  = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        SEC_VCOUNT = 3'd0,
        SEC_U      = 3'd1,
        SEC_V      = 3'd2,
        SEC_HEIGHT = 3'd3,
        SEC_TCOUNT = 3'd4,
        SEC_INDEX  = 3'd5
    } section_t;

    // One assembled word with its classification, handed from front to back.
    typedef struct packed {
        section_t          section;
        logic [WORD_W-1:0] word;
        logic              last;   // end of array, or end of tile for counts and indices
        logic              wide;   // index uses 32-bit arithmetic
    } task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/qmsd_front.sv =====
// Byte parser: skips the header, assembles words and classifies them into tasks.
`timescale 1ns / 1ps

module qmsd_front #(
    parameter int unsigned HEADER_BYTES = qmsd_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  qmsd_pkg::queue_status_t q_status,
    output logic                   push,
    output qmsd_pkg::task_t        push_task
);

    localparam logic [qmsd_pkg::HDR_CNT_W-1:0] HDR_LIMIT = qmsd_pkg::HDR_CNT_W'(HEADER_BYTES);

    qmsd_pkg::phase_t                   phase_reg, phase_next;
    logic [qmsd_pkg::HDR_CNT_W-1:0]     hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]                         byte_idx_reg, byte_idx_next;
    logic [qmsd_pkg::WORD_W-1:0]        word_reg, word_next;
    logic [qmsd_pkg::WORD_W-1:0]        vtotal_reg, vtotal_next;
    logic [qmsd_pkg::WORD_W-1:0]        left_reg, left_next;
    logic                               wide_reg, wide_next;
    logic                               accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        logic                        consume;
        logic                        four_bytes;
        logic                        complete;
        logic [1:0]                  idx_inc;
        logic [qmsd_pkg::WORD_W-1:0] w;
        logic                        last;

        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        byte_idx_next = byte_idx_reg;
        word_next     = word_reg;
        vtotal_next   = vtotal_reg;
        left_next     = left_reg;
        wide_next     = wide_reg;
        push          = 1'b0;
        push_task     = '0;
        consume       = 1'b1;
        four_bytes    = 1'b0;
        complete      = 1'b0;
        idx_inc       = 2'd0;
        w             = '0;
        last          = 1'b0;

        // Start of tile: restart the parser before this byte is parsed.
        if (s_tuser)
        begin
            phase_next    = qmsd_pkg::PH_HEADER;
            hdr_cnt_next  = '0;
            byte_idx_next = '0;
            word_next     = '0;
            vtotal_next   = '0;
            left_next     = '0;
            wide_next     = 1'b0;
        end

        if (phase_next == qmsd_pkg::PH_HEADER)
        begin
            if (hdr_cnt_next >= HDR_LIMIT)
            begin
                phase_next = qmsd_pkg::PH_VCOUNT;
            end
            else
            begin
                hdr_cnt_next = hdr_cnt_next + 1'b1;
                if (hdr_cnt_next >= HDR_LIMIT)
                begin
                    phase_next = qmsd_pkg::PH_VCOUNT;
                end
                consume = 1'b0;
            end
        end

        if (consume && phase_next != qmsd_pkg::PH_DONE)
        begin
            four_bytes = (phase_next == qmsd_pkg::PH_VCOUNT) ||
                         (phase_next == qmsd_pkg::PH_TCOUNT) ||
                         (phase_next == qmsd_pkg::PH_INDEX && wide_next);
            word_next  = word_next | ({24'd0, s_tdata} << {byte_idx_next, 3'b000});
            idx_inc    = byte_idx_next + 2'd1;
            complete   = (idx_inc == 2'd0) || (!four_bytes && idx_inc >= 2'd2);
            byte_idx_next = complete ? 2'd0 : idx_inc;
        end

        if (complete)
        begin
            w         = word_next;
            word_next = '0;
            push      = 1'b1;
            unique case (phase_next)
                qmsd_pkg::PH_VCOUNT:
                begin
                    vtotal_next = w;
                    wide_next   = w > qmsd_pkg::WIDE_LIMIT;
                    left_next   = w;
                    phase_next  = (w == '0) ? qmsd_pkg::PH_TCOUNT : qmsd_pkg::PH_U;
                    push_task   = '{qmsd_pkg::SEC_VCOUNT, w, 1'b0, 1'b0};
                end
                qmsd_pkg::PH_U, qmsd_pkg::PH_V, qmsd_pkg::PH_HEIGHT:
                begin
                    left_next = left_next - 1'b1;
                    last      = (left_next == '0);
                    push_task = '{qmsd_pkg::SEC_U, {16'd0, w[15:0]}, last, 1'b0};
                    unique case (phase_next)
                        qmsd_pkg::PH_U:
                        begin
                            push_task.section = qmsd_pkg::SEC_U;
                            if (last) phase_next = qmsd_pkg::PH_V;
                        end
                        qmsd_pkg::PH_V:
                        begin
                            push_task.section = qmsd_pkg::SEC_V;
                            if (last) phase_next = qmsd_pkg::PH_HEIGHT;
                        end
                        default:
                        begin
                            push_task.section = qmsd_pkg::SEC_HEIGHT;
                            if (last) phase_next = qmsd_pkg::PH_TCOUNT;
                        end
                    endcase
                    if (last)
                    begin
                        left_next = vtotal_next;
                    end
                end
                qmsd_pkg::PH_TCOUNT:
                begin
                    // Index count is 3 * count, wrapping at 32 bits.
                    left_next  = w + {w[30:0], 1'b0};
                    last       = (left_next == '0);
                    phase_next = last ? qmsd_pkg::PH_DONE : qmsd_pkg::PH_INDEX;
                    push_task  = '{qmsd_pkg::SEC_TCOUNT, w, last, 1'b0};
                end
                qmsd_pkg::PH_INDEX:
                begin
                    left_next = left_next - 1'b1;
                    last      = (left_next == '0);
                    if (last)
                    begin
                        phase_next = qmsd_pkg::PH_DONE;
                    end
                    push_task = '{qmsd_pkg::SEC_INDEX,
                                  wide_next ? w : {16'd0, w[15:0]}, last, wide_next};
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= qmsd_pkg::PH_HEADER;
            hdr_cnt_reg  <= '0;
            byte_idx_reg <= '0;
            word_reg     <= '0;
            vtotal_reg   <= '0;
            left_reg     <= '0;
            wide_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            byte_idx_reg <= byte_idx_next;
            word_reg     <= word_next;
            vtotal_reg   <= vtotal_next;
            left_reg     <= left_next;
            wide_reg     <= wide_next;
        end
    end

endmodule

// ===== hw/rtl/qmsd_queue.sv =====
// Short task queue between the parser and the decoder.
`timescale 1ns / 1ps

module qmsd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  qmsd_pkg::task_t         push_task,
    input  logic                    pop,
    output qmsd_pkg::task_t         head_task,
    output qmsd_pkg::queue_status_t status
);

    localparam int unsigned PTR_W = $clog2(qmsd_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(qmsd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(qmsd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(qmsd_pkg::QUEUE_DEPTH - 1);

    qmsd_pkg::task_t  mem [qmsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_task    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/qmsd_back.sv =====
// Decoder: zig-zag running sums, high-water index decode and the output register.
`timescale 1ns / 1ps

module qmsd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qmsd_pkg::task_t         head_task,
    input  qmsd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic [2:0]              m_tuser,
    output logic                    m_tlast
);

    logic                                out_valid_reg, out_valid_next;
    logic [qmsd_pkg::WORD_W-1:0]         out_value_reg, out_value_next;
    logic [2:0]                          out_sec_reg, out_sec_next;
    logic                                out_last_reg, out_last_next;
    logic [qmsd_pkg::COORD_W-1:0]        coord_reg, coord_next;
    logic [qmsd_pkg::WORD_W-1:0]         hw_reg, hw_next;

    assign pop      = !q_status.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_sec_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        logic [qmsd_pkg::COORD_W-1:0] code16;
        logic [qmsd_pkg::COORD_W-1:0] zz;
        logic [qmsd_pkg::COORD_W-1:0] sum;
        logic [qmsd_pkg::COORD_W-1:0] diff16;

        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_sec_next   = out_sec_reg;
        out_last_next  = out_last_reg;
        coord_next     = coord_reg;
        hw_next        = hw_reg;
        code16         = head_task.word[15:0];
        zz             = {1'b0, code16[15:1]} ^ {qmsd_pkg::COORD_W{code16[0]}};
        sum            = coord_reg + zz;
        diff16         = hw_reg[15:0] - code16;

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_sec_next   = head_task.section;
            out_last_next  = head_task.last;
            out_value_next = head_task.word;
            unique case (head_task.section)
                qmsd_pkg::SEC_VCOUNT:
                begin
                    out_last_next = 1'b0;
                    coord_next    = '0;
                end
                qmsd_pkg::SEC_U, qmsd_pkg::SEC_V, qmsd_pkg::SEC_HEIGHT:
                begin
                    out_last_next  = 1'b0;
                    out_value_next = {16'd0, sum};
                    // Restart the sum for the next array.
                    coord_next     = head_task.last ? '0 : sum;
                end
                qmsd_pkg::SEC_TCOUNT:
                begin
                    hw_next = '0;
                end
                qmsd_pkg::SEC_INDEX:
                begin
                    if (head_task.wide)
                    begin
                        out_value_next = hw_reg - head_task.word;
                        if (head_task.word == '0)
                        begin
                            hw_next = hw_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_value_next = {16'd0, diff16};
                        if (code16 == '0)
                        begin
                            hw_next = {16'd0, hw_reg[15:0] + 16'd1};
                        end
                    end
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            coord_reg     <= '0;
            hw_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            coord_reg     <= coord_next;
            hw_reg        <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_sec_reg   <= out_sec_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== hw/rtl/quantized_mesh_stream_decoder.sv =====
// Top level of the quantized mesh stream decoder.
`timescale 1ns / 1ps
//
//  group | dir | payload                                   | request when
//  s_*   | in  | tdata[7:0] data_byte, tuser tile_start     | s_tvalid && s_tready
//  m_*   | out | tdata[31:0] value, tuser[2:0] section,     | m_tvalid && m_tready
//        |     | tlast tile_done                            |
//
//  One byte per cycle while s_tready is high; a result leaves through the parser,
//  the two-entry queue and the output register after the byte that completes its word.
//  s_tready drops only when the queue is full, i.e. after the output stalls.
//  rst_n clears parser, queue and decoder state; payload registers are not reset.

module quantized_mesh_stream_decoder #(
    parameter int unsigned HEADER_BYTES = qmsd_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] tile_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser,   // [2:0] section
    output logic        m_tlast
);

    logic                    push;
    logic                    pop;
    qmsd_pkg::task_t         push_task;
    qmsd_pkg::task_t         head_task;
    qmsd_pkg::queue_status_t q_status;

    qmsd_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_task (push_task)
    );

    qmsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head_task (head_task),
        .status    (q_status)
    );

    qmsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_task (head_task),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // An empty queue must never hold off the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> s_tready)
        else $error("input stalled with empty queue");

    // Coordinates are 16-bit sums, zero-extended, and never marked last.
    a_coord_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == qmsd_pkg::SEC_U || m_tuser == qmsd_pkg::SEC_V ||
                      m_tuser == qmsd_pkg::SEC_HEIGHT)) |-> (m_tdata[31:16] == 16'd0 && !m_tlast))
        else $error("coordinate result out of range or marked last");

    // The vertex count never ends a tile.
    a_vcount_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == qmsd_pkg::SEC_VCOUNT) |-> !m_tlast)
        else $error("vertex count marked as end of tile");

endmodule
